// ===== sv/smg_pkg.sv =====
package smg_pkg;

    // Buffer depth of each sequence and the widths that follow from it
    localparam int DEPTH  = 32;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Input beat kinds carried on s_tuser
    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_MERGE  = 2'd2
    } cmd_t;

    // Merge sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PICK,
        ST_SEND
    } state_t;

    // Decision from the compare unit
    typedef struct packed {
        logic pri_b;
        logic take_a;
    } pick_t;

endpackage

// ===== sv/smg_pick.sv =====
module smg_pick
    import smg_pkg::*;
(
    input  logic signed [DATA_W-1:0] head_a,
    input  logic signed [DATA_W-1:0] head_b,
    input  logic                     a_left,
    input  logic                     b_left,
    input  logic                     first,
    input  logic                     pri_b_held,
    output pick_t                    pick
);

    logic [DATA_W:0] diff;
    logic            a_lt_b;
    logic            equal;
    logic            b_lt_a;
    logic            pri_b;

    // One signed subtract serves both orderings and equality
    assign diff   = {head_a[DATA_W-1], head_a} - {head_b[DATA_W-1], head_b};
    assign a_lt_b = diff[DATA_W];
    assign equal  = (diff == '0);
    assign b_lt_a = !a_lt_b && !equal;

    // Primary is A unless both hold elements and B's head is strictly smaller
    assign pri_b = first ? (a_left && b_left && b_lt_a) : pri_b_held;

    // Take from A when B is spent, else order the heads; ties go to the primary
    always_comb begin
        pick.pri_b = pri_b;
        if (!a_left) begin
            pick.take_a = 1'b0;
        end else if (!b_left) begin
            pick.take_a = 1'b1;
        end else if (pri_b) begin
            pick.take_a = a_lt_b;
        end else begin
            pick.take_a = !b_lt_a;
        end
    end

endmodule

// ===== sv/sorted_two_list_merge.sv =====
// Two-way merge of sorted sequences. Load beats (s_tuser = load A or load B) append a
// signed 32-bit value to buffer A or B, one beat per cycle; each buffer holds 32 values,
// further loads are dropped and set a sticky flag that is reported on m_tuser[1] of the
// next merge run and then cleared. A merge beat makes the block emit both buffers merged
// in ascending order as one run closed by m_tlast, then empties both buffers. Sequence A
// leads unless B's first value is strictly smaller; on equal values the leading sequence
// gives its element first. Two empty buffers give no run. While a run is in progress
// s_tready is low. Each result passes a registered read of both buffers (FETCH), one pass
// through the shared compare unit (PICK) and the output beat (SEND), which waits for
// m_tready; the next result is read only after the previous output beat is taken.
module sorted_two_list_merge
    import smg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] value
    input  logic [1:0]        s_tuser,   // [1:0] cmd
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [31:0] merged_value
    output logic [1:0]        m_tuser,   // [0] from_b, [1] dropped
    output logic              m_tlast
);

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_a_reg, count_a_next;
    logic [CNT_W-1:0]  count_b_reg, count_b_next;
    logic [CNT_W-1:0]  ia_reg, ia_next;
    logic [CNT_W-1:0]  ib_reg, ib_next;
    logic              overflow_reg, overflow_next;
    logic              first_reg, first_next;
    logic              pri_b_reg, pri_b_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              from_b_reg, from_b_next;
    logic              last_reg, last_next;
    logic              dropped_reg, dropped_next;
    logic [DATA_W-1:0] head_a_reg;
    logic [DATA_W-1:0] head_b_reg;

    logic              s_beat;
    logic              m_beat;
    logic              wr_a;
    logic              wr_b;
    logic              a_left;
    logic              b_left;
    pick_t             pick;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;
    assign a_left = (ia_reg < count_a_reg);
    assign b_left = (ib_reg < count_b_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tdata  = data_reg;
    assign m_tuser  = {dropped_reg, from_b_reg};
    assign m_tlast  = last_reg;

    smg_pick u_pick (
        .head_a     (head_a_reg),
        .head_b     (head_b_reg),
        .a_left     (a_left),
        .b_left     (b_left),
        .first      (first_reg),
        .pri_b_held (pri_b_reg),
        .pick       (pick)
    );

    // Buffer writes on load beats, registered reads at the merge cursors
    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[count_a_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (wr_b) begin
            mem_b[count_b_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (state_reg == ST_FETCH) begin
            head_a_reg <= mem_a[ia_reg[ADDR_W-1:0]];
            head_b_reg <= mem_b[ib_reg[ADDR_W-1:0]];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            overflow_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_a_reg  <= count_a_next;
            count_b_reg  <= count_b_next;
            overflow_reg <= overflow_next;
        end
    end

    // Cursors and output payload
    always_ff @(posedge aclk) begin
        ia_reg      <= ia_next;
        ib_reg      <= ib_next;
        first_reg   <= first_next;
        pri_b_reg   <= pri_b_next;
        data_reg    <= data_next;
        from_b_reg  <= from_b_next;
        last_reg    <= last_next;
        dropped_reg <= dropped_next;
    end

    // Sequencer: next state and register updates
    always_comb begin
        state_next    = state_reg;
        count_a_next  = count_a_reg;
        count_b_next  = count_b_reg;
        overflow_next = overflow_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        first_next    = first_reg;
        pri_b_next    = pri_b_reg;
        data_next     = data_reg;
        from_b_next   = from_b_reg;
        last_next     = last_reg;
        dropped_next  = dropped_reg;
        wr_a          = 1'b0;
        wr_b          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    case (cmd_t'(s_tuser))
                        CMD_LOAD_A: begin
                            if (count_a_reg < CNT_W'(DEPTH)) begin
                                wr_a         = 1'b1;
                                count_a_next = count_a_reg + CNT_W'(1);
                            end else begin
                                overflow_next = 1'b1;
                            end
                        end
                        CMD_LOAD_B: begin
                            if (count_b_reg < CNT_W'(DEPTH)) begin
                                wr_b         = 1'b1;
                                count_b_next = count_b_reg + CNT_W'(1);
                            end else begin
                                overflow_next = 1'b1;
                            end
                        end
                        CMD_MERGE: begin
                            if (count_a_reg == '0 && count_b_reg == '0) begin
                                overflow_next = 1'b0;
                            end else begin
                                ia_next      = '0;
                                ib_next      = '0;
                                first_next   = 1'b1;
                                dropped_next = overflow_reg;
                                state_next   = ST_FETCH;
                            end
                        end
                        default: begin
                            // unused code: drop the beat
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                state_next = ST_PICK;
            end
            ST_PICK: begin
                // advance the cursor of the chosen side and load the output beat
                ia_next     = ia_reg + CNT_W'(pick.take_a);
                ib_next     = ib_reg + CNT_W'(!pick.take_a);
                pri_b_next  = pick.pri_b;
                first_next  = 1'b0;
                data_next   = pick.take_a ? head_a_reg : head_b_reg;
                from_b_next = !pick.take_a;
                last_next   = (ia_next == count_a_reg) && (ib_next == count_b_reg);
                state_next  = ST_SEND;
            end
            ST_SEND: begin
                if (m_beat) begin
                    if (last_reg) begin
                        count_a_next  = '0;
                        count_b_next  = '0;
                        overflow_next = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Loading and emitting never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output sides active together");

    // Fill counts never pass the buffer depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_a_reg <= CNT_W'(DEPTH)) && (count_b_reg <= CNT_W'(DEPTH)))
        else $error("buffer count beyond depth");

    // Cursors stay within the loaded elements while a run is in progress
    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (ia_reg <= count_a_reg) && (ib_reg <= count_b_reg))
        else $error("merge cursor past buffer fill");

    // The closing beat of a run empties both buffers and the drop flag
    a_run_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && m_tlast) |=> (count_a_reg == '0) && (count_b_reg == '0) && !overflow_reg
                                && s_tready)
        else $error("buffers not emptied after a run");

    // The last beat of a run has consumed every loaded element
    a_last_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (ia_reg == count_a_reg) && (ib_reg == count_b_reg))
        else $error("run closed with elements left");

endmodule
